// ----- rtl/core/mgra_pkg.sv -----
// Package for the modified Givens rotation block: fp32 constants, mode codes,
// the unpacked operand struct and the helpers used by the multiply and add stages.
// No dependencies.
package mgra_pkg;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO  = 32'h0000_0000;

  // Valid stages ahead of the output register.
  localparam int PIPE_DEPTH = 5;

  typedef enum logic [1:0] {
    MODE_FULL = 2'd0,
    MODE_UNIT_DIAG = 2'd1,
    MODE_UNIT_OFF = 2'd2,
    MODE_PASS = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_H11 = 3'd1,
    REG_H12 = 3'd2,
    REG_H21 = 3'd3,
    REG_H22 = 3'd4
  } reg_idx_t;

  // Unpacked fp32 operand.
  typedef struct packed {
    logic        sign;
    logic [8:0]  exp;     // biased exponent, subnormals mapped to 1
    logic [23:0] man;     // significand with hidden bit
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] a);
    fp_unp_t u;
    u.sign    = a[31];
    u.exp     = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    u.man     = {(a[30:23] != 8'd0), a[22:0]};
    u.is_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    u.is_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    u.is_zero = (a[30:0] == 31'd0);
    return u;
  endfunction

  // Count of leading zeros of a 48-bit word.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round and pack a result: sig holds the value sig * 2^(exp - bias - 46),
  // with the leading one expected near bit 46; sticky collects lost bits.
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] exp,
                                           input logic [47:0] sig, input logic sticky);
    logic [5:0]          lz;
    logic signed [11:0]  e;
    logic [47:0]         s;
    logic [11:0]         sh;
    logic                st;
    logic [24:0]         m;
    logic                g;
    logic                r;
    logic [31:0]         res;
    st = sticky;
    lz = lzc48(sig);
    if (sig == 48'd0) begin
      return {sign, 31'd0};
    end
    // Normalize so the leading one sits at bit 47, exponent tracking it.
    s = sig << lz;
    e = exp + 12'sd1 - 12'(lz);
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd48) begin
        st = st | (s != 48'd0);
        s = 48'd0;
      end else begin
        for (int i = 0; i < 48; i++) begin
          if (12'(i) < sh) st = st | s[i];
        end
        s = s >> sh;
      end
      e = 12'sd0;
    end
    m = {1'b0, s[47:24]};
    g = s[23];
    st = st | (s[22:0] != 23'd0);
    r = g && (st || m[0]);
    m = m + 25'(r);
    if (m[24]) begin
      m = m >> 1;
      e = e + 12'sd1;
    end else if (e == 12'sd0 && m[23]) begin
      e = 12'sd1;
    end
    if (e >= 12'sd255) begin
      res = {sign, 8'hFF, 23'd0};
    end else begin
      res = {sign, e[7:0], m[22:0]};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/modified_givens_rotation_apply.sv -----
// Modified Givens rotation on one fp32 pair (x, y) per word, in the four
// forms of mode_r. A word passes through the multiplier stages, the adder
// stages, a delay register and the output register, where mode_r selects
// the raw pass-through pair or the rotated pair. A new word is taken every
// cycle; the whole pipeline advances together and holds when the output stalls.
// Depends on mgra_pkg, mgra_fmul and mgra_fadd.
module modified_givens_rotation_apply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x_out,
  output logic [31:0] out_y_out
);

  mgra_pkg::mode_t mode_r;
  logic [31:0] h11_r, h12_r, h21_r, h22_r;
  logic        adv;
  logic [mgra_pkg::PIPE_DEPTH-1:0] vld_r;

  // Operand words chosen per mode before the multipliers.
  logic [31:0] ma0, mb0, ma1, mb1, ma2, mb2, ma3, mb3;
  logic [31:0] p0, p1, p2, p3, sx, sy;
  logic [31:0] x_d1_r, x_d2_r, y_d1_r, y_d2_r;
  logic [31:0] px_d1_r, px_d2_r, px_d3_r, px_d4_r;
  logic [31:0] py_d1_r, py_d2_r, py_d3_r, py_d4_r;
  logic [31:0] ox_r, oy_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mgra_pkg::MODE_PASS;
      h11_r  <= mgra_pkg::FP_ONE;
      h12_r  <= mgra_pkg::FP_ZERO;
      h21_r  <= mgra_pkg::FP_ZERO;
      h22_r  <= mgra_pkg::FP_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgra_pkg::REG_MODE: mode_r <= mgra_pkg::mode_t'(cfg_data[1:0]);
        mgra_pkg::REG_H11:  h11_r <= cfg_data;
        mgra_pkg::REG_H12:  h12_r <= cfg_data;
        mgra_pkg::REG_H21:  h21_r <= cfg_data;
        mgra_pkg::REG_H22:  h22_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves when the output word is free or being taken.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[mgra_pkg::PIPE_DEPTH-2:0], in_valid};
      out_valid <= vld_r[mgra_pkg::PIPE_DEPTH-1];
    end
  end

  // Operand selection: h*x and h*y terms; unit terms multiply by one (minus one for h21 in MODE_UNIT_OFF).
  always_comb begin
    ma0 = h11_r;  mb0 = in_x_in;
    ma1 = h12_r;  mb1 = in_y_in;
    ma2 = h21_r;  mb2 = in_x_in;
    ma3 = h22_r;  mb3 = in_y_in;
    unique case (mode_r)
      mgra_pkg::MODE_UNIT_DIAG: begin
        ma0 = mgra_pkg::FP_ONE;
        ma3 = mgra_pkg::FP_ONE;
      end
      mgra_pkg::MODE_UNIT_OFF: begin
        ma1 = mgra_pkg::FP_ONE;
        ma2 = {1'b1, mgra_pkg::FP_ONE[30:0]};
      end
      default: ;
    endcase
  end

  mgra_fmul u_m0 (.clk(clk), .en(adv), .a(ma0), .b(mb0), .p(p0));
  mgra_fmul u_m1 (.clk(clk), .en(adv), .a(ma1), .b(mb1), .p(p1));
  mgra_fmul u_m2 (.clk(clk), .en(adv), .a(ma2), .b(mb2), .p(p2));
  mgra_fmul u_m3 (.clk(clk), .en(adv), .a(ma3), .b(mb3), .p(p3));

  mgra_fadd u_ax (.clk(clk), .en(adv), .a(p0), .b(p1), .s(sx));
  mgra_fadd u_ay (.clk(clk), .en(adv), .a(p3), .b(p2), .s(sy));

  // Raw inputs ride along for pass-through.
  always_ff @(posedge clk) begin
    if (adv) begin
      px_d1_r <= in_x_in;  py_d1_r <= in_y_in;
      px_d2_r <= px_d1_r;  py_d2_r <= py_d1_r;
      px_d3_r <= px_d2_r;  py_d3_r <= py_d2_r;
      px_d4_r <= px_d3_r;  py_d4_r <= py_d3_r;
      x_d1_r  <= px_d4_r;  y_d1_r  <= py_d4_r;
      x_d2_r  <= sx;       y_d2_r  <= sy;
    end
  end

  // Output register: the user must keep mode static while words are in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode_r == mgra_pkg::MODE_PASS) begin
        ox_r <= x_d1_r;
        oy_r <= y_d1_r;
      end else begin
        ox_r <= x_d2_r;
        oy_r <= y_d2_r;
      end
    end
  end

  assign out_x_out = ox_r;
  assign out_y_out = oy_r;

endmodule

// ----- rtl/core/mgra_fmul.sv -----
// One registered fp32 multiply stage pair: significand product, then rounding.
// Depends on mgra_pkg.
module mgra_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  mgra_pkg::fp_unp_t ua;
  mgra_pkg::fp_unp_t ub;
  logic [47:0]        prod_r;
  logic signed [11:0] exp_r;
  logic               sign_r;
  logic               nan_r;
  logic               inf_r;
  logic               zero_r;
  logic [31:0]        p_r;

  assign ua = mgra_pkg::fp_unpack(a);
  assign ub = mgra_pkg::fp_unpack(b);

  // Stage one: raw product and special-case flags.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ua.man * ub.man;
      exp_r  <= 12'($signed({3'b0, ua.exp})) + 12'($signed({3'b0, ub.exp})) - 12'sd127;
      sign_r <= ua.sign ^ ub.sign;
      nan_r  <= ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
                (ub.is_inf && ua.is_zero);
      inf_r  <= ua.is_inf || ub.is_inf;
      zero_r <= ua.is_zero || ub.is_zero;
    end
  end

  // Stage two: normalize and round.
  always_ff @(posedge clk) begin
    if (en) begin
      if (nan_r) begin
        p_r <= mgra_pkg::QNAN;
      end else if (inf_r) begin
        p_r <= {sign_r, 8'hFF, 23'd0};
      end else if (zero_r) begin
        p_r <= {sign_r, 31'd0};
      end else begin
        p_r <= mgra_pkg::fp_round(sign_r, exp_r, prod_r, 1'b0);
      end
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/mgra_fadd.sv -----
// Registered fp32 adder: alignment stage, then add, normalize and round.
// Depends on mgra_pkg.
module mgra_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  mgra_pkg::fp_unp_t ua;
  mgra_pkg::fp_unp_t ub;
  logic               swap;
  mgra_pkg::fp_unp_t  big;
  mgra_pkg::fp_unp_t  sml;
  logic [8:0]         diff;
  logic [49:0]        sml_ext;
  logic               sml_st;

  logic [49:0]        big_r;
  logic [49:0]        sml_r;
  logic               st_r;
  logic               bs_r;
  logic               ss_r;
  logic signed [11:0] exp_r;
  logic               nan_r;
  logic               inf_r;
  logic               infs_r;
  logic               zz_r;
  logic               zs_r;
  logic [31:0]        s_r;

  logic [49:0]        sum;
  logic               diffsgn;

  assign ua = mgra_pkg::fp_unpack(a);
  assign ub = mgra_pkg::fp_unpack(b);
  assign swap = {ub.exp, ub.man} > {ua.exp, ua.man};
  assign big = swap ? ub : ua;
  assign sml = swap ? ua : ub;
  assign diff = big.exp - sml.exp;

  // Smaller operand shifted right into the guard bits, plus sticky. Two
  // spare bits on top leave room for the carry of the sum.
  always_comb begin
    sml_ext = {2'b00, sml.man, 24'd0};
    sml_st = 1'b0;
    if (diff > 9'd49) begin
      sml_st = (sml.man != 24'd0);
      sml_ext = 50'd0;
    end else begin
      for (int i = 0; i < 50; i++) begin
        if (9'(i) < diff) sml_st = sml_st | sml_ext[i];
      end
      sml_ext = sml_ext >> diff;
    end
  end

  // Stage one: alignment.
  always_ff @(posedge clk) begin
    if (en) begin
      big_r  <= {2'b00, big.man, 24'd0};
      sml_r  <= sml_ext;
      st_r   <= sml_st;
      bs_r   <= big.sign;
      ss_r   <= sml.sign;
      exp_r  <= 12'($signed({3'b0, big.exp}));
      nan_r  <= ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && (ua.sign != ub.sign));
      inf_r  <= ua.is_inf || ub.is_inf;
      infs_r <= ua.is_inf ? ua.sign : ub.sign;
      zz_r   <= ua.is_zero && ub.is_zero;
      zs_r   <= ua.sign && ub.sign;
    end
  end

  // Sticky bit subtracts as one lost unit below the window.
  assign diffsgn = bs_r ^ ss_r;
  assign sum = diffsgn ? (big_r - sml_r - 50'(st_r)) : (big_r + sml_r);

  // Stage two: add, normalize, round.
  always_ff @(posedge clk) begin
    if (en) begin
      if (nan_r) begin
        s_r <= mgra_pkg::QNAN;
      end else if (inf_r) begin
        s_r <= {infs_r, 8'hFF, 23'd0};
      end else if (zz_r) begin
        s_r <= {zs_r, 31'd0};
      end else if (sum == 50'd0 && !st_r) begin
        s_r <= 32'd0;
      end else begin
        // sum carries two more bits than the product format; fold them in.
        s_r <= mgra_pkg::fp_round(bs_r, exp_r + 12'sd1, sum[49:2],
                                  (sum[1:0] != 2'd0) || st_r);
      end
    end
  end

  assign s = s_r;

endmodule
